/* hw/rtl/bfd_pkg.sv */
// Black frame detector: shared types, register indexes and constants.
// No dependencies; imported by every module of the block.
package bfd_pkg;

  localparam int DEF_MAX_DIM      = 8192;
  localparam int DEF_GRID_DIVISOR = 10;

  localparam int CFG_DATA_W  = 14;
  localparam int DIM_REG_W   = 14;
  localparam int THR_W       = 10;
  localparam int PCT_W       = 7;
  localparam int CHAN_W      = 8;
  localparam int SUM_W       = 10;
  localparam int COUNT_W     = 18;
  localparam int PROD_W      = COUNT_W + 8;
  localparam int SMALL_LIMIT = 10;
  localparam int PERCENT_SCALE = 100;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [DIM_REG_W-1:0] RST_FRAME_WIDTH    = 14'd1920;
  localparam logic [DIM_REG_W-1:0] RST_FRAME_HEIGHT   = 14'd1080;
  localparam logic [THR_W-1:0]     RST_DARK_THRESHOLD = 10'd18;
  localparam logic [PCT_W-1:0]     RST_BLACK_PERCENT  = 7'd90;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_DARK_THRESHOLD = 2'd2,
    REG_BLACK_PERCENT  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic               is_black;
    logic [COUNT_W-1:0] dark_samples;
    logic [COUNT_W-1:0] total_samples;
  } result_t;

  // per-frame job handed from front to back
  typedef struct packed {
    logic               small_frame;
    logic [COUNT_W-1:0] dark;
    logic [COUNT_W-1:0] total;
  } job_t;

  typedef struct packed {
    logic push;
  } front_status_t;

endpackage

/* hw/rtl/bfd_front.sv */
// Black frame detector front: raster tracking, grid sampling, dark counting.
// Also derives the grid step by reciprocal multiplication. Uses bfd_pkg.
module bfd_front import bfd_pkg::*; #(
  parameter int MAX_DIM      = DEF_MAX_DIM,
  parameter int GRID_DIVISOR = DEF_GRID_DIVISOR
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pixel_valid,
  output logic                 pixel_stall,
  input  pixel_t               pixel,
  input  logic [DIM_REG_W-1:0] frame_width,
  input  logic [DIM_REG_W-1:0] frame_height,
  input  logic [THR_W-1:0]     dark_threshold,
  input  logic                 restart,
  input  logic                 queue_full,
  output job_t                 job,
  output front_status_t        status
);

  localparam int DIM_W    = $clog2(MAX_DIM + 1);
  localparam int RECIP_SH = DIM_W + $clog2(GRID_DIVISOR);
  localparam int RECIP_W  = DIM_W + 1;
  localparam int SCALED_W = DIM_W + RECIP_W;
  localparam longint RECIP = ((longint'(1) << RECIP_SH) + longint'(GRID_DIVISOR) - 1)
                             / longint'(GRID_DIVISOR);

  localparam int RW_CL = (int'(RST_FRAME_WIDTH) > MAX_DIM) ? MAX_DIM : int'(RST_FRAME_WIDTH);
  localparam int RH_CL = (int'(RST_FRAME_HEIGHT) > MAX_DIM) ? MAX_DIM : int'(RST_FRAME_HEIGHT);
  localparam int RMIN  = (RW_CL < RH_CL) ? RW_CL : RH_CL;
  localparam int RQ    = RMIN / GRID_DIVISOR;
  localparam int RESET_STEP = (RQ < 1) ? 1 : RQ;

  logic [DIM_W-1:0] col_pos, row_pos, col_phase, row_phase, step;
  logic [COUNT_W-1:0] sample_cnt, dark_cnt;

  logic [DIM_W-1:0] w_cl, h_cl, min_dim;
  logic [SUM_W-1:0] sum;
  logic sampled, is_dark, line_end, frame_end, take, small_frame;
  logic [COUNT_W-1:0] sample_next, dark_next;
  logic [DIM_W-1:0] col_phase_next, row_phase_next;
  logic [SCALED_W-1:0] min_scaled;
  logic [DIM_W-1:0] step_quo, step_calc;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  assign w_cl    = clamp_dim(frame_width);
  assign h_cl    = clamp_dim(frame_height);
  assign min_dim = (w_cl < h_cl) ? w_cl : h_cl;

  // floor(min_dim / GRID_DIVISOR) by multiplying with a rounded-up reciprocal
  assign min_scaled = SCALED_W'(min_dim) * SCALED_W'(RECIP);
  assign step_quo   = DIM_W'(min_scaled >> RECIP_SH);
  assign step_calc  = (step_quo == '0) ? DIM_W'(1) : step_quo;

  assign pixel_stall = restart | queue_full;
  assign take        = pixel_valid & ~pixel_stall;

  assign sum = SUM_W'(pixel.red) + SUM_W'(pixel.green) + SUM_W'(pixel.blue);
  assign sampled = (col_phase == '0) && (row_phase == '0);
  assign is_dark = sum < dark_threshold;
  assign sample_next = (sampled && sample_cnt != COUNT_MAX) ? sample_cnt + 1'b1 : sample_cnt;
  assign dark_next = (sampled && is_dark && dark_cnt != COUNT_MAX) ? dark_cnt + 1'b1
                                                                   : dark_cnt;

  assign line_end    = ({1'b0, col_pos} + 1'b1) >= {1'b0, w_cl};
  assign frame_end   = line_end && (({1'b0, row_pos} + 1'b1) >= {1'b0, h_cl});
  assign small_frame = (int'(w_cl) < SMALL_LIMIT) || (int'(h_cl) < SMALL_LIMIT);

  assign col_phase_next = (({1'b0, col_phase} + 1'b1) >= {1'b0, step}) ? '0 : col_phase + 1'b1;
  assign row_phase_next = (({1'b0, row_phase} + 1'b1) >= {1'b0, step}) ? '0 : row_phase + 1'b1;

  assign job.small_frame = small_frame;
  assign job.dark        = dark_next;
  assign job.total       = sample_next;
  assign status.push     = take & frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos    <= '0;
      row_pos    <= '0;
      col_phase  <= '0;
      row_phase  <= '0;
      sample_cnt <= '0;
      dark_cnt   <= '0;
      step       <= DIM_W'(RESET_STEP);
    end else if (restart) begin
      col_pos    <= '0;
      row_pos    <= '0;
      col_phase  <= '0;
      row_phase  <= '0;
      sample_cnt <= '0;
      dark_cnt   <= '0;
      step       <= step_calc;
    end else if (take) begin
      if (frame_end) begin
        col_pos    <= '0;
        row_pos    <= '0;
        col_phase  <= '0;
        row_phase  <= '0;
        sample_cnt <= '0;
        dark_cnt   <= '0;
      end else begin
        sample_cnt <= sample_next;
        dark_cnt   <= dark_next;
        if (line_end) begin
          col_pos   <= '0;
          col_phase <= '0;
          row_pos   <= row_pos + 1'b1;
          row_phase <= row_phase_next;
        end else begin
          col_pos   <= col_pos + 1'b1;
          col_phase <= col_phase_next;
        end
      end
    end
  end

endmodule

/* hw/rtl/bfd_fifo.sv */
// Black frame detector: two-entry job queue between front and back.
// Uses job_t from bfd_pkg.
module bfd_fifo import bfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output job_t head,
  output logic not_empty,
  output logic full
);

  job_t mem [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign head      = mem[rd_ptr];
  assign not_empty = count != 2'd0;
  assign full      = count == 2'd2;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* hw/rtl/bfd_back.sv */
// Black frame detector back: percentage judgment and result register.
// floor(100*dark/total) > p is evaluated as 100*dark >= (p+1)*total. Uses bfd_pkg.
module bfd_back import bfd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  job_t             head,
  input  logic             not_empty,
  output logic             pop,
  input  logic [PCT_W-1:0] black_percent,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result
);

  logic [PROD_W-1:0] dark_scaled, limit;
  logic [PCT_W:0]    pct_p1;
  logic              black;

  assign pct_p1      = {1'b0, black_percent} + 1'b1;
  assign dark_scaled = PROD_W'(head.dark) * PROD_W'(PERCENT_SCALE);
  assign limit       = PROD_W'(head.total) * PROD_W'(pct_p1);
  assign black = head.small_frame | ((head.total != '0) && (dark_scaled >= limit));

  assign pop = not_empty & (~result_valid | ~result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (~result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.is_black      <= black;
      result.dark_samples  <= head.dark;
      result.total_samples <= head.total;
    end
  end

endmodule

/* hw/rtl/black_frame_detector.sv */
// Black frame detector top: config registers, front, job queue, back.
// Depends on bfd_pkg, bfd_front, bfd_fifo, bfd_back.
//
//  channel  | signals                          | payload
//  ---------+----------------------------------+----------------------------
//  pixel    | pixel_valid / pixel_stall        | pixel_t (red, green, blue)
//  result   | result_valid / result_stall      | result_t, one per frame
//  config   | cfg_valid / cfg_ready            | cfg_index, cfg_data
//
// One pixel per cycle while pixel_stall is low. result_valid rises after the last
// pixel of a frame has passed through the job queue and then the result register.
// A width or height write restarts the frame and raises pixel_stall in the cycle
// after the write while positions and counts clear and the grid step reloads.
// Reset is synchronous; the grid step for the reset size is loaded directly.
// pixel_stall also rises when the two-entry job queue is full.
module black_frame_detector import bfd_pkg::*; #(
  parameter int MAX_DIM      = DEF_MAX_DIM,
  parameter int GRID_DIVISOR = DEF_GRID_DIVISOR
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  pixel_t                pixel,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DIM_REG_W-1:0] frame_width, frame_height;
  logic [THR_W-1:0]     dark_threshold;
  logic [PCT_W-1:0]     black_percent;
  logic                 size_written;
  logic                 cfg_wr;

  job_t          job, head;
  front_status_t status;
  logic          q_full, q_not_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= RST_FRAME_WIDTH;
      frame_height   <= RST_FRAME_HEIGHT;
      dark_threshold <= RST_DARK_THRESHOLD;
      black_percent  <= RST_BLACK_PERCENT;
      size_written   <= 1'b0;
    end else begin
      size_written <= 1'b0;
      if (cfg_wr) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            frame_width  <= cfg_data[DIM_REG_W-1:0];
            size_written <= 1'b1;
          end
          REG_FRAME_HEIGHT: begin
            frame_height <= cfg_data[DIM_REG_W-1:0];
            size_written <= 1'b1;
          end
          REG_DARK_THRESHOLD: begin
            dark_threshold <= cfg_data[THR_W-1:0];
          end
          REG_BLACK_PERCENT: begin
            black_percent <= cfg_data[PCT_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  bfd_front #(
    .MAX_DIM      (MAX_DIM),
    .GRID_DIVISOR (GRID_DIVISOR)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .pixel_valid    (pixel_valid),
    .pixel_stall    (pixel_stall),
    .pixel          (pixel),
    .frame_width    (frame_width),
    .frame_height   (frame_height),
    .dark_threshold (dark_threshold),
    .restart        (size_written),
    .queue_full     (q_full),
    .job            (job),
    .status         (status)
  );

  bfd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (status.push),
    .push_data (job),
    .pop       (q_pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  bfd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .not_empty     (q_not_empty),
    .pop           (q_pop),
    .black_percent (black_percent),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    status.push |-> !q_full)
    else $error("job pushed into full queue");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed or dropped");

  a_size_write_stalls: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT))
      |=> pixel_stall)
    else $error("pixel accepted right after size write");

  a_counts_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.dark_samples <= result.total_samples))
    else $error("dark count exceeds sample count");

endmodule
